@@ design/itoa_pkg.sv @@
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared sizes, character codes, payload types and helpers of the integer to
// ASCII formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

  // Sizes
  localparam int VALUE_BITS  = 16;
  localparam int MAX_CHARS   = 17;
  localparam int RADIX_BITS  = 6;
  localparam int WIDTH_BITS  = 5;
  localparam int CHAR_BITS   = 7;
  localparam int RADIX_MIN   = 2;
  localparam int RADIX_MAX   = 36;

  localparam int STACK_DEPTH = VALUE_BITS;
  localparam int DIGIT_BITS  = $clog2(VALUE_BITS + 1);
  localparam int CYC_BITS    = $clog2(VALUE_BITS);
  localparam int CHAR_LIMIT  = (MAX_CHARS > VALUE_BITS + 1) ? MAX_CHARS : VALUE_BITS + 1;
  localparam int CNT_RAW     = $clog2(CHAR_LIMIT + 1);
  localparam int CNT_BITS    = (CNT_RAW > WIDTH_BITS) ? CNT_RAW : WIDTH_BITS;

  // Character codes
  localparam logic [CHAR_BITS-1:0] CH_ZERO   = 7'h30;
  localparam logic [CHAR_BITS-1:0] CH_SPACE  = 7'h20;
  localparam logic [CHAR_BITS-1:0] CH_MINUS  = 7'h2D;
  localparam logic [CHAR_BITS-1:0] ALPHA_GAP = 7'd7;

  // One input transaction
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  signed_mode;
    logic [RADIX_BITS-1:0] radix;
    logic [WIDTH_BITS-1:0] width;
    logic                  zero_pad;
  } itoa_in_t;

  // One output transaction
  typedef struct packed {
    logic [CHAR_BITS-1:0] char_code;
    logic                 last;
  } itoa_out_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [RADIX_BITS-1:0] remainder;
  } div_res_t;

  // Digit stack control
  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctl_t;

  // Map a digit value to its ASCII character: 0..9 then A..Z
  function automatic logic [CHAR_BITS-1:0] digit_char(input logic [RADIX_BITS-1:0] d);
    logic [CHAR_BITS-1:0] base;
    base = CH_ZERO + CHAR_BITS'(d);
    if (d >= RADIX_BITS'(10)) begin
      base = base + ALPHA_GAP;
    end
    return base;
  endfunction

endpackage

`default_nettype wire

@@ design/itoa_divider.sv @@
// ----------------------------------------------------------------------------
// itoa_divider
// Bit-serial restoring divider: one quotient bit per cycle, dividend shifted
// out at the top while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_divider
  import itoa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire logic [RADIX_BITS-1:0] divisor,
  output div_res_t                   res
);

  logic [VALUE_BITS-1:0] quo;
  logic [RADIX_BITS:0]   rem;
  logic [RADIX_BITS-1:0] dvs;
  logic [CYC_BITS-1:0]   cnt;
  logic                  running;
  logic                  done;

  logic [RADIX_BITS:0]   shifted;
  logic                  fits;

  // Bring in the next dividend bit and trial-subtract
  assign shifted = {rem[RADIX_BITS-1:0], quo[VALUE_BITS-1]};
  assign fits    = (shifted >= {1'b0, dvs});

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + CYC_BITS'(1);
        if (cnt == CYC_BITS'(VALUE_BITS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      quo <= {quo[VALUE_BITS-2:0], fits};
      rem <= fits ? (shifted - {1'b0, dvs}) : shifted;
    end
  end

  assign res.done      = done;
  assign res.quotient  = quo;
  assign res.remainder = rem[RADIX_BITS-1:0];

  // Remainder of a finished division stays below the divisor
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < {1'b0, dvs}))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

@@ design/itoa_digit_stack.sv @@
// ----------------------------------------------------------------------------
// itoa_digit_stack
// Last-in first-out shift register of digit characters. Digits arrive least
// significant first and leave most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_digit_stack
  import itoa_pkg::*;
(
  input  wire logic                 clk,
  input  wire stack_ctl_t           ctl,
  input  wire logic [CHAR_BITS-1:0] push_char,
  output logic      [CHAR_BITS-1:0] top_char
);

  logic [CHAR_BITS-1:0] entry [STACK_DEPTH];

  // Push shifts everything down one place; pop shifts it back up
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      entry[0] <= push_char;
      for (int i = 1; i < STACK_DEPTH; i++) begin
        entry[i] <= entry[i-1];
      end
    end else if (ctl.pop) begin
      for (int i = 0; i < STACK_DEPTH - 1; i++) begin
        entry[i] <= entry[i+1];
      end
    end
  end

  assign top_char = entry[0];

endmodule

`default_nettype wire

@@ design/integer_to_ascii_formatter.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats one value as ASCII characters in radix 2..36, with optional sign
// and left padding, one character per strobe.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Each digit
// comes from one full division in the bit-serial divider. Characters leave
// leftmost first, one per cycle, each on result for a single cycle with
// strobe high; result.last marks the final one. The receiver cannot stall,
// so it must take every strobe. busy drops when the last character is
// registered, so the next transaction may be taken while that character is
// still on the ports.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_formatter
  import itoa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire itoa_in_t operand,
  output logic          busy,
  output logic          strobe,
  output itoa_out_t     result
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_PAD   = 5'b00100,
    S_SIGN  = 5'b01000,
    S_DIGIT = 5'b10000
  } state_t;

  state_t                state;
  logic                  sgn;
  logic [CHAR_BITS-1:0]  pad_char;
  logic [RADIX_BITS-1:0] radix_q;
  logic [CNT_BITS-1:0]   width_q;
  logic [DIGIT_BITS-1:0] n_digits;
  logic [CNT_BITS-1:0]   pad_cnt;

  logic                  accept;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] in_mag;
  logic [RADIX_BITS-1:0] in_radix;
  logic [CNT_BITS-1:0]   in_width;

  div_res_t              div_res;
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [RADIX_BITS-1:0] div_divisor;
  logic                  digit_done;
  logic                  final_digit;

  stack_ctl_t            stk_ctl;
  logic [CHAR_BITS-1:0]  top_char;

  logic [DIGIT_BITS-1:0] digits_next;
  logic [CNT_BITS-1:0]   body_len;
  logic [CNT_BITS-1:0]   pad_need;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Clamp radix and width, take the magnitude of the value
  always_comb begin
    in_neg = operand.signed_mode && operand.value[VALUE_BITS-1];
    in_mag = in_neg ? (VALUE_BITS'(0) - operand.value) : operand.value;
    if (operand.radix < RADIX_BITS'(RADIX_MIN)) begin
      in_radix = RADIX_BITS'(RADIX_MIN);
    end else if (operand.radix > RADIX_BITS'(RADIX_MAX)) begin
      in_radix = RADIX_BITS'(RADIX_MAX);
    end else begin
      in_radix = operand.radix;
    end
    if (CNT_BITS'(operand.width) > CNT_BITS'(MAX_CHARS)) begin
      in_width = CNT_BITS'(MAX_CHARS);
    end else begin
      in_width = CNT_BITS'(operand.width);
    end
  end

  // Divider feed: first pass from the input, later passes from the quotient
  assign digit_done   = (state == S_DIV) && div_res.done;
  assign final_digit  = (div_res.quotient == '0);
  assign div_start    = accept || (digit_done && !final_digit);
  assign div_dividend = accept ? in_mag : div_res.quotient;
  assign div_divisor  = accept ? in_radix : radix_q;

  // Digit stack control
  assign stk_ctl.push = digit_done;
  assign stk_ctl.pop  = (state == S_DIGIT);

  // Pad length once the digit count is known
  always_comb begin
    digits_next = n_digits + DIGIT_BITS'(1);
    body_len    = CNT_BITS'(digits_next) + CNT_BITS'(sgn);
    pad_need    = (width_q > body_len) ? (width_q - body_len) : '0;
  end

  itoa_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .res      (div_res)
  );

  itoa_digit_stack u_stack (
    .clk       (clk),
    .ctl       (stk_ctl),
    .push_char (digit_char(div_res.remainder)),
    .top_char  (top_char)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (digit_done && final_digit) begin
            priority if (pad_need != '0) begin
              state <= S_PAD;
            end else if (sgn) begin
              state <= S_SIGN;
            end else begin
              state <= S_DIGIT;
            end
          end
        end
        S_PAD: begin
          strobe <= 1'b1;
          if (pad_cnt == CNT_BITS'(1)) begin
            state <= sgn ? S_SIGN : S_DIGIT;
          end
        end
        S_SIGN: begin
          strobe <= 1'b1;
          state  <= S_DIGIT;
        end
        S_DIGIT: begin
          strobe <= 1'b1;
          if (n_digits == DIGIT_BITS'(1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Per-transaction registers and output character
  always_ff @(posedge clk) begin
    if (accept) begin
      sgn      <= in_neg;
      pad_char <= operand.zero_pad ? CH_ZERO : CH_SPACE;
      radix_q  <= in_radix;
      width_q  <= in_width;
      n_digits <= '0;
    end
    if (digit_done) begin
      n_digits <= digits_next;
      pad_cnt  <= pad_need;
    end
    if (state == S_PAD) begin
      pad_cnt            <= pad_cnt - CNT_BITS'(1);
      result.char_code   <= pad_char;
      result.last        <= 1'b0;
    end
    if (state == S_SIGN) begin
      result.char_code <= CH_MINUS;
      result.last      <= 1'b0;
    end
    if (state == S_DIGIT) begin
      n_digits         <= n_digits - DIGIT_BITS'(1);
      result.char_code <= top_char;
      result.last      <= (n_digits == DIGIT_BITS'(1));
    end
  end

  // Nothing follows the final character in the next cycle
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |=> !strobe)
    else $error("character strobed right after the final one");

  // A taken transaction makes the block busy
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("block not busy after taking a transaction");

  // Digits are left whenever one is to be sent
  a_digits_left: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGIT) |-> (n_digits != '0))
    else $error("digit output with an empty stack");

endmodule

`default_nettype wire
